>>> design/tse_pkg.sv
package tse_pkg;

    localparam int KEY_W      = 32;
    localparam int IDX_W      = 8;
    localparam int POS_W      = 8;
    localparam int CNT_W      = 9;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } res_t;

endpackage

>>> design/tse_ram.sv
module tse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> design/tse_search.sv
module tse_search import tse_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [KEY_W-1:0]    key,
    input  logic [$clog2(DEPTH):0]     count,
    output logic                       idle,
    output logic [$clog2(DEPTH)-1:0]   rd_addr_a,
    output logic [$clog2(DEPTH)-1:0]   rd_addr_b,
    input  logic [KEY_W-1:0]           rd_data_a,
    input  logic [KEY_W-1:0]           rd_data_b,
    output logic                       res_valid,
    input  logic                       res_ready,
    output res_t                       res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int K  = AW + 2;
    localparam int PW = 2 * AW + 2;
    localparam logic [AW+1:0] RECIP3 = (AW+2)'((2**K + 2) / 3);

    state_t state_reg, state_next;

    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           end_reg, end_next;
    logic [AW-1:0]           third_reg, third_next;
    logic [AW-1:0]           p1_reg, p1_next;
    logic [AW-1:0]           p2_reg, p2_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    res_t                    res_reg, res_next;

    logic                    range_empty;
    logic [CW-1:0]           span;
    logic [AW-1:0]           span_m1;
    logic [PW-1:0]           prod;
    logic [AW-1:0]           p1_w;
    logic [AW-1:0]           p2_w;
    logic signed [KEY_W-1:0] v1;
    logic signed [KEY_W-1:0] v2;
    logic                    hit1;
    logic                    hit2;

    assign range_empty = (end_reg <= lo_reg);
    assign span        = end_reg - lo_reg - CW'(1);
    assign span_m1     = AW'(span);
    assign prod        = PW'(span_m1) * PW'(RECIP3);
    assign p1_w        = AW'(lo_reg + CW'(third_reg));
    assign p2_w        = AW'(end_reg - CW'(1) - CW'(third_reg));
    assign v1          = $signed(rd_data_a);
    assign v2          = $signed(rd_data_b);
    assign hit1        = (v1 == key_reg);
    assign hit2        = (v2 == key_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (range_empty) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (hit1 || hit2) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CALC;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        idle      = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        res       = res_reg;
        rd_addr_a = p1_w;
        rd_addr_b = p2_w;
    end

    always_comb begin
        lo_next    = lo_reg;
        end_next   = end_reg;
        third_next = third_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    lo_next           = '0;
                    end_next          = count;
                    key_next          = key;
                    res_next.found    = 1'b0;
                    res_next.position = '0;
                end
            end
            ST_CALC: begin
                third_next = AW'(prod >> K);
            end
            ST_READ: begin
                p1_next = p1_w;
                p2_next = p2_w;
            end
            ST_CMP: begin
                priority if (hit1) begin
                    res_next.found    = 1'b1;
                    res_next.position = POS_W'(p1_reg);
                end else if (hit2) begin
                    res_next.found    = 1'b1;
                    res_next.position = POS_W'(p2_reg);
                end else if (key_reg < v1) begin
                    end_next = CW'(p1_reg);
                end else if (key_reg > v2) begin
                    lo_next = CW'(p2_reg) + CW'(1);
                end else begin
                    lo_next  = CW'(p1_reg) + CW'(1);
                    end_next = CW'(p2_reg);
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        end_reg   <= end_next;
        third_reg <= third_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        key_reg   <= key_next;
        res_reg   <= res_next;
    end

endmodule

>>> design/ternary_search_engine_top.sv
// Ternary search engine over a store of DEPTH signed 32-bit elements.
// Input channel (s_*): a beat with s_req_type = load writes s_value into
// entry s_load_index (ignored at or above DEPTH) and returns no result; a
// beat with s_req_type = search looks for s_value among the first
// element_count entries and returns one result beat on m_* carrying
// m_found and m_position (0 when not found).
// element_count is written through the APB port at address 0; counts above
// DEPTH act as DEPTH. Write it only while no search is in flight.
// Loads may follow back to back. A search runs R ternary rounds, each a
// divide-by-three multiply, a dual-port store read and a compare, and then
// hands its result to the output register; at 256 entries R is at most 6.
// The next input beat is taken once the sequencer is back in idle.
// Only one search is in flight; s_ready drops while it runs. A finished
// result sits in the output register while the next input beat is taken;
// if m_ready stays low with a result still held, the next search waits in
// its last state until the register frees.
// Reset clears element_count, the sequencer and m_valid. Store contents
// are undefined until loaded.
module ternary_search_engine_top import tse_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [IDX_W-1:0]        s_load_index,
    input  logic signed [KEY_W-1:0] s_value,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_found,
    output logic [POS_W-1:0]        m_position,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [CNT_W-1:0] element_count_reg, element_count_next;
    logic             m_valid_reg, m_valid_next;
    res_t             m_res_reg, m_res_next;

    logic             cfg_wr;
    logic             in_beat;
    logic             search_start;
    logic             load_wr;
    logic [CW-1:0]    count_eff;
    logic             srch_idle;
    logic [AW-1:0]    rd_addr_a;
    logic [AW-1:0]    rd_addr_b;
    logic [KEY_W-1:0] rd_data_a;
    logic [KEY_W-1:0] rd_data_b;
    logic             res_valid;
    logic             res_ready;
    res_t             res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ?
                    APB_DATA_W'(element_count_reg) : '0;

    always_comb begin
        element_count_next = element_count_reg;
        if (cfg_wr && (paddr[2] == REG_ELEMENT_COUNT)) begin
            element_count_next = CNT_W'(pwdata);
        end
    end

    assign count_eff = (32'(element_count_reg) > 32'(DEPTH)) ?
                       CW'(DEPTH) : CW'(element_count_reg);

    assign s_ready      = srch_idle;
    assign in_beat      = s_valid && s_ready;
    assign search_start = in_beat && (s_req_type == REQ_SEARCH);
    assign load_wr      = in_beat && (s_req_type == REQ_LOAD) &&
                          (32'(s_load_index) < 32'(DEPTH));

    tse_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (load_wr),
        .wr_addr   (AW'(s_load_index)),
        .wr_data   (s_value),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    tse_search #(
        .DEPTH (DEPTH)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (search_start),
        .key       (s_value),
        .count     (count_eff),
        .idle      (srch_idle),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            element_count_reg <= element_count_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_res_reg.found;
    assign m_position = m_res_reg.position;

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tse_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int ITEM_TARGET = 1950;
    localparam int CALM_TAIL   = 300;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 800_000;

    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(4 * REG_ELEMENT_COUNT);
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4 * (REG_ELEMENT_COUNT + 1));

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef enum int {
        FILL_RISING,
        FILL_REPEATS,
        FILL_FLAT,
        FILL_SHUFFLED,
        FILL_SPAN
    } fill_kind_t;

    class search_tracker;
        logic signed [KEY_W-1:0] store [STORE_DEPTH];
        logic [CNT_W-1:0]        element_count;
        res_t                    pending_answers[$];
        int                      mismatches;
        int                      hits;
        int                      loads;
        int                      searches;

        function new();
            element_count = '0;
        endfunction

        function void set_count(logic [CNT_W-1:0] c);
            element_count = c;
        endfunction

        function logic signed [KEY_W-1:0] entry(int i);
            return store[i];
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
            end
        endfunction

        function res_t ternary_lookup(logic signed [KEY_W-1:0] key);
            res_t r;
            int   lo;
            int   hi;
            int   third;
            int   p1;
            int   p2;
            r  = '0;
            lo = 0;
            hi = (int'(element_count) > STORE_DEPTH ? STORE_DEPTH : int'(element_count)) - 1;
            while (hi >= lo) begin
                third = (hi - lo) / 3;
                p1    = lo + third;
                p2    = hi - third;
                if (store[p1] == key) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(p1);
                    return r;
                end
                if (store[p2] == key) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(p2);
                    return r;
                end
                if (key < store[p1]) begin
                    hi = p1 - 1;
                end else if (key > store[p2]) begin
                    lo = p2 + 1;
                end else begin
                    lo = p1 + 1;
                    hi = p2 - 1;
                end
            end
            return r;
        endfunction

        function void note_request(logic kind, logic [IDX_W-1:0] idx,
                                   logic signed [KEY_W-1:0] val);
            if (kind == REQ_LOAD) begin
                store[idx] = val;
                loads++;
            end else begin
                pending_answers.push_back(ternary_lookup(val));
                searches++;
            end
        endfunction

        function void check_answer(logic found, logic [POS_W-1:0] position);
            res_t want;
            if (pending_answers.size() == 0) begin
                flag("result with no search pending", 0, {found, position});
                return;
            end
            want = pending_answers.pop_front();
            if (found !== want.found) flag("found", want.found, found);
            if (position !== want.position) flag("position", want.position, position);
            if (want.found) hits++;
        endfunction
    endclass

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic                    s_req_type   = REQ_LOAD;
    logic [IDX_W-1:0]        s_load_index = '0;
    logic signed [KEY_W-1:0] s_value      = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic                    m_found;
    logic [POS_W-1:0]        m_position;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr        = '0;
    logic [APB_DATA_W-1:0]   pwdata       = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    search_tracker tracker = new();

    bit calm;
    bit tx_quiet;
    bit rx_quiet;
    int stall_left;
    int items_sent;
    int cycles;
    bit touched [STORE_DEPTH];

    ternary_search_engine_top #(.DEPTH(STORE_DEPTH)) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_load_index (s_load_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_position   (m_position),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results pending",
                     cycles, tracker.outstanding());
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side: check each beat, stall in random bursts
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_answer(m_found, m_position);
        if ($urandom_range(0, 199) == 0) rx_quiet <= !rx_quiet;
        if (calm) begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic signed [KEY_W-1:0] val);
        int gap;
        gap = 0;
        if (!calm && !tx_quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_load_index <= idx;
        s_value      <= val;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(kind, idx, val);
        if (kind == REQ_LOAD) touched[idx] = 1'b1;
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (wr && addr == COUNT_ADDR) tracker.set_count(data[CNT_W-1:0]);
        if (!wr && addr == COUNT_ADDR) begin
            if (prdata !== APB_DATA_W'(tracker.element_count)) begin
                tracker.flag("element_count readback", tracker.element_count, prdata);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic fill_store(input int n, input fill_kind_t kind);
        longint                  cur;
        longint                  stride_lo;
        longint                  stride_hi;
        logic signed [KEY_W-1:0] v;
        case ($urandom_range(0, 2))
            0:       stride_hi = 3;
            1:       stride_hi = 1000;
            default: stride_hi = 16_000_000;
        endcase
        stride_lo = 1;
        if (kind == FILL_REPEATS) begin
            stride_lo = 0;
            stride_hi = 2;
        end
        cur = longint'($signed($urandom()));
        if (kind == FILL_SPAN) begin
            cur       = longint'(KEY_MIN);
            stride_lo = 1;
            stride_hi = 16_000_000;
        end
        if (cur + n * stride_hi > longint'(KEY_MAX)) cur = longint'(KEY_MAX) - n * stride_hi;
        for (int i = 0; i < n; i++) begin
            case (kind)
                FILL_FLAT:     v = KEY_W'(cur);
                FILL_SHUFFLED: v = $urandom();
                default: begin
                    v   = KEY_W'(cur);
                    cur = cur + longint'($urandom_range(int'(stride_lo), int'(stride_hi)));
                end
            endcase
            if (kind == FILL_SPAN && i == n - 1 && n > 1) v = KEY_MAX;
            send_beat(REQ_LOAD, IDX_W'(i), v);
        end
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(int n);
        int                      r;
        logic signed [KEY_W-1:0] base;
        r = $urandom_range(0, 9);
        if (n == 0 || r == 7) return $urandom();
        base = tracker.entry($urandom_range(0, n - 1));
        if (r <= 5) return base;
        if (r == 6) return $urandom_range(0, 1) ? base + 1 : base - 1;
        if (r == 8) return KEY_MIN;
        return KEY_MAX;
    endfunction

    initial begin
        int               phase;
        int               cnt;
        int               n;
        int               n_search;
        int               guard;
        int               settings;
        bit               need_fill;
        fill_kind_t       kind;
        logic [APB_DATA_W-1:0] upper;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // count zero after reset: nothing can be found
        send_beat(REQ_SEARCH, 8'hff, 32'sd0);
        send_beat(REQ_SEARCH, 8'h00, KEY_MIN);
        send_beat(REQ_LOAD, 8'd0, KEY_MIN);
        send_beat(REQ_LOAD, 8'd1, -32'sd5);
        send_beat(REQ_LOAD, 8'd2, 32'sd7);
        send_beat(REQ_LOAD, 8'd3, KEY_MAX);
        send_beat(REQ_LOAD, 8'd255, 32'sh5a5a_a5a5);

        // write past the register map: count must stay zero
        wait_idle();
        apb_access(1'b1, SPARE_ADDR, 32'd3);
        apb_access(1'b0, COUNT_ADDR, '0);
        send_beat(REQ_SEARCH, 8'h00, 32'sd7);

        wait_idle();
        apb_access(1'b1, COUNT_ADDR, 32'hffff_fe04);
        apb_access(1'b0, COUNT_ADDR, '0);
        send_beat(REQ_SEARCH, 8'h00, KEY_MIN);
        send_beat(REQ_SEARCH, 8'h00, KEY_MAX);
        send_beat(REQ_SEARCH, 8'h00, -32'sd5);
        send_beat(REQ_SEARCH, 8'h00, 32'sd7);
        send_beat(REQ_SEARCH, 8'h00, 32'sd0);
        send_beat(REQ_SEARCH, 8'h00, -32'sd6);
        send_beat(REQ_SEARCH, 8'h00, 32'sd8);

        wait_idle();
        apb_access(1'b1, COUNT_ADDR, 32'd1);
        send_beat(REQ_SEARCH, 8'h00, KEY_MIN);
        send_beat(REQ_SEARCH, 8'h00, KEY_MAX);
        settings = 3;

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: cnt = STORE_DEPTH;
                1: cnt = 511;
                2: cnt = 0;
                3: cnt = 2;
                default: begin
                    case ($urandom_range(0, 15))
                        0:       cnt = 0;
                        1:       cnt = 1;
                        2:       cnt = 2;
                        3:       cnt = $urandom_range(STORE_DEPTH, 511);
                        4:       cnt = STORE_DEPTH - 1;
                        default: cnt = $urandom_range(3, 48);
                    endcase
                end
            endcase
            calm     = (items_sent >= ITEM_TARGET - CALM_TAIL);
            tx_quiet = ($urandom_range(0, 3) == 0);

            wait_idle();
            upper = $urandom_range(0, 3) == 0 ? ($urandom() & ~32'h1ff) : '0;
            apb_access(1'b1, COUNT_ADDR, upper | APB_DATA_W'(cnt));
            if ($urandom_range(0, 2) == 0) apb_access(1'b0, COUNT_ADDR, '0);
            settings++;

            n = cnt > STORE_DEPTH ? STORE_DEPTH : cnt;
            need_fill = 1'b0;
            for (int i = 0; i < n; i++) if (!touched[i]) need_fill = 1'b1;
            if (need_fill || n <= 64 || $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    4:       kind = FILL_REPEATS;
                    5:       kind = FILL_FLAT;
                    6:       kind = FILL_SHUFFLED;
                    7:       kind = FILL_SPAN;
                    default: kind = FILL_RISING;
                endcase
                fill_store(n, kind);
            end

            if (n == 0) n_search = $urandom_range(4, 10);
            else if (n == STORE_DEPTH) n_search = 90;
            else n_search = $urandom_range(15, 50);
            for (int k = 0; k < n_search; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_beat(REQ_LOAD, IDX_W'($urandom()), $urandom());
                end
                send_beat(REQ_SEARCH, IDX_W'($urandom()), pick_key(n));
            end
            phase++;
        end

        s_valid <= 1'b0;
        guard = 0;
        while (tracker.outstanding() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE) @(posedge aclk);
        if (tracker.outstanding() != 0) begin
            tracker.flag("searches left without a result", 0, tracker.outstanding());
        end

        $display("covered %0d loads and %0d searches (%0d hits) over %0d count settings",
                 tracker.loads, tracker.searches, tracker.hits, settings);
        $display("%0d mismatches in %0d cycles", tracker.mismatches, cycles);
        if (tracker.mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
